/* hw/rtl/scd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scd_pkg - shared definitions for the scanline crossing stop detector
// Field widths, register indexes, reset values and the scan hit record.
// ----------------------------------------------------------------------------
package scd_pkg;

  localparam int POS_W   = 11;   // row / column index width
  localparam int GRAY_W  = 8;
  localparam int TICK_W  = 16;
  localparam int TRANS_W = 12;
  localparam int COUNT_W = 16;
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 16;

  // Structural defaults, handed to the top level parameters
  localparam int LINE_COUNT_DEF  = 5;
  localparam int ROW_SPACING_DEF = 5;
  localparam int COL_STEP_DEF    = 3;

  // Pixels at or beyond this row or column are ignored
  localparam int MAX_DIM = 2048;

  // Input item kinds
  localparam logic FUNC_PIXEL = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

  // Register indexes
  localparam logic [CFG_AW-1:0] REG_GRAY_THRESHOLD  = 3'd0;
  localparam logic [CFG_AW-1:0] REG_MIN_TRANSITIONS = 3'd1;
  localparam logic [CFG_AW-1:0] REG_STOP_TICKS      = 3'd2;
  localparam logic [CFG_AW-1:0] REG_COOLDOWN_TICKS  = 3'd3;
  localparam logic [CFG_AW-1:0] REG_SCAN_ROW_BASE   = 3'd4;
  localparam logic [CFG_AW-1:0] REG_COL_START       = 3'd5;
  localparam logic [CFG_AW-1:0] REG_COL_END         = 3'd6;

  // Register reset values
  localparam logic [GRAY_W-1:0] GRAY_THRESHOLD_RST  = 8'd160;
  localparam logic [7:0]        MIN_TRANSITIONS_RST = 8'd10;
  localparam logic [TICK_W-1:0] STOP_TICKS_RST      = 16'd3000;
  localparam logic [TICK_W-1:0] COOLDOWN_TICKS_RST  = 16'd10000;
  localparam logic [POS_W-1:0]  SCAN_ROW_BASE_RST   = 11'd120;
  localparam logic [POS_W-1:0]  COL_START_RST       = 11'd32;
  localparam logic [POS_W-1:0]  COL_END_RST         = 11'd288;

  localparam logic [TICK_W-1:0]  TICK_MAX  = {TICK_W{1'b1}};
  localparam logic [TRANS_W-1:0] TRANS_MAX = {TRANS_W{1'b1}};
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Scan decision for one pixel
  typedef struct packed {
    logic hit;     // pixel is a sample point on a scan row
    logic first;   // sample at the start column, sets the reference level
  } scd_hit_t;

endpackage

/* hw/rtl/scd_scan.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scd_scan - sample point decode
// Flags pixels that sit on a scan row and on a sampled column of the window.
// ----------------------------------------------------------------------------
module scd_scan #(
  parameter int LINE_COUNT  = scd_pkg::LINE_COUNT_DEF,
  parameter int ROW_SPACING = scd_pkg::ROW_SPACING_DEF,
  parameter int COL_STEP    = scd_pkg::COL_STEP_DEF
) (
  input  logic [scd_pkg::POS_W-1:0] row,
  input  logic [scd_pkg::POS_W-1:0] col,
  input  logic [scd_pkg::POS_W-1:0] scan_row_base,
  input  logic [scd_pkg::POS_W-1:0] col_start,
  input  logic [scd_pkg::POS_W-1:0] col_end,
  output scd_pkg::scd_hit_t         hit
);

  localparam int PW = scd_pkg::POS_W;

  // Divisibility by COL_STEP through a scaled reciprocal: d is a multiple
  // of the step exactly when the fractional part of d * MUL stays below MUL.
  localparam int STEP_LOG = $clog2(COL_STEP);
  localparam int SH       = PW + STEP_LOG + 1;
  localparam logic [SH:0] MUL = (SH+1)'(((2 ** SH) + COL_STEP - 1) / COL_STEP);

  logic [LINE_COUNT-1:0] line_match;
  logic                  row_hit;
  logic                  in_range;
  logic                  in_window;
  logic [PW-1:0]         col_ofs;
  logic [PW+SH:0]        prod;
  logic                  on_step;

  for (genvar i = 0; i < LINE_COUNT; i++) begin : g_line
    localparam logic [PW-1:0] OFF = PW'(i * ROW_SPACING);
    // A line that would lie above the image matches nothing
    assign line_match[i] = (scan_row_base >= OFF) && ((scan_row_base - OFF) == row);
  end

  assign row_hit   = |line_match;
  assign in_range  = (32'(row) < scd_pkg::MAX_DIM) && (32'(col) < scd_pkg::MAX_DIM);
  assign in_window = (col >= col_start) && (col < col_end);
  assign col_ofs   = col - col_start;
  assign prod      = (PW+SH+1)'(col_ofs) * (PW+SH+1)'(MUL);
  assign on_step   = ({1'b0, prod[SH-1:0]} < MUL);

  always_comb begin
    hit.hit   = in_range && row_hit && in_window && on_step;
    hit.first = (col == col_start);
  end

endmodule

/* hw/rtl/scanline_crossing_stop_detector_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scanline_crossing_stop_detector_unit - stripe crossing stop detector
// Watches scan rows of a gray raster stream, counts black/white changes and
// runs the timed stop, cooldown and crossing count at each frame end.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one item per transfer:
//   a pixel (in_func = 0) with gray, row, col and frame_last, or a time
//   tick (in_func = 1). Only a pixel with frame_last set yields a result
//   on the output channel (out_valid / out_stall); all other items update
//   internal state silently.
//   Throughput is one item per clock while in_stall stays low. Each item is
//   held in the input register and evaluated against the detector state on
//   the edge that moves it on, which also loads the result register, so a
//   frame end reaches out_valid through the input and result registers (two
//   register stages). It makes a single pass through the scan decode,
//   transition counter and stop logic.
//   While the receiver stalls a pending result, pixels and ticks that give
//   no result keep flowing; in_stall rises only when a second frame-end
//   result reaches the input register and the output register is full.
//   Configuration writes (cfg_we, cfg_addr, cfg_wdata) take effect on the
//   next edge and belong between items, with the block idle.
//   Reset (rst_n low, synchronous) restores register defaults, clears the
//   stop and counters and marks the cooldown as over.
// ----------------------------------------------------------------------------
module scanline_crossing_stop_detector_unit #(
  parameter int LINE_COUNT  = scd_pkg::LINE_COUNT_DEF,
  parameter int ROW_SPACING = scd_pkg::ROW_SPACING_DEF,
  parameter int COL_STEP    = scd_pkg::COL_STEP_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // configuration
  input  logic                         cfg_we,
  input  logic [scd_pkg::CFG_AW-1:0]   cfg_addr,
  input  logic [scd_pkg::CFG_DW-1:0]   cfg_wdata,
  // input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_func,
  input  logic [scd_pkg::GRAY_W-1:0]   in_gray,
  input  logic [scd_pkg::POS_W-1:0]    in_row,
  input  logic [scd_pkg::POS_W-1:0]    in_col,
  input  logic                         in_frame_last,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_vehicle_hold,
  output logic                         out_crossing_now,
  output logic                         out_stop_started,
  output logic                         out_stop_released,
  output logic                         out_cool_active,
  output logic [scd_pkg::TRANS_W-1:0]  out_frame_transitions,
  output logic [scd_pkg::COUNT_W-1:0]  out_crossing_total
);

  localparam int PW = scd_pkg::POS_W;
  localparam int TW = scd_pkg::TICK_W;
  localparam int NW = scd_pkg::TRANS_W;
  localparam int CW = scd_pkg::COUNT_W;

  // ---------------- configuration registers ----------------
  logic [scd_pkg::GRAY_W-1:0] gray_threshold_r;
  logic [7:0]                 min_transitions_r;
  logic [TW-1:0]              stop_ticks_r;
  logic [TW-1:0]              cooldown_ticks_r;
  logic [PW-1:0]              scan_row_base_r;
  logic [PW-1:0]              col_start_r;
  logic [PW-1:0]              col_end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gray_threshold_r  <= scd_pkg::GRAY_THRESHOLD_RST;
      min_transitions_r <= scd_pkg::MIN_TRANSITIONS_RST;
      stop_ticks_r      <= scd_pkg::STOP_TICKS_RST;
      cooldown_ticks_r  <= scd_pkg::COOLDOWN_TICKS_RST;
      scan_row_base_r   <= scd_pkg::SCAN_ROW_BASE_RST;
      col_start_r       <= scd_pkg::COL_START_RST;
      col_end_r         <= scd_pkg::COL_END_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        scd_pkg::REG_GRAY_THRESHOLD:  gray_threshold_r  <= cfg_wdata[7:0];
        scd_pkg::REG_MIN_TRANSITIONS: min_transitions_r <= cfg_wdata[7:0];
        scd_pkg::REG_STOP_TICKS:      stop_ticks_r      <= cfg_wdata;
        scd_pkg::REG_COOLDOWN_TICKS:  cooldown_ticks_r  <= cfg_wdata;
        scd_pkg::REG_SCAN_ROW_BASE:   scan_row_base_r   <= cfg_wdata[PW-1:0];
        scd_pkg::REG_COL_START:       col_start_r       <= cfg_wdata[PW-1:0];
        scd_pkg::REG_COL_END:         col_end_r         <= cfg_wdata[PW-1:0];
        default: ;  // writes beyond the register list are dropped
      endcase
    end
  end

  // ---------------- input register ----------------
  logic                       s1_valid_r;
  logic                       s1_func_r;
  logic [scd_pkg::GRAY_W-1:0] s1_gray_r;
  logic [PW-1:0]              s1_row_r;
  logic [PW-1:0]              s1_col_r;
  logic                       s1_last_r;

  logic in_xfer;
  logic s1_result;   // the held item is a frame end and yields a result
  logic s1_adv;      // the held item is evaluated at this edge
  logic out_xfer;

  assign out_xfer  = out_valid && !out_stall;
  assign s1_result = (s1_func_r == scd_pkg::FUNC_PIXEL) && s1_last_r;
  // Hold only a result-producing item while the output register cannot drain
  assign s1_adv    = s1_valid_r && !(s1_result && out_valid && out_stall);
  assign in_stall  = s1_valid_r && !s1_adv;
  assign in_xfer   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_func_r <= in_func;
      s1_gray_r <= in_gray;
      s1_row_r  <= in_row;
      s1_col_r  <= in_col;
      s1_last_r <= in_frame_last;
    end
  end

  // ---------------- scan decode ----------------
  scd_pkg::scd_hit_t scan_hit;

  scd_scan #(
    .LINE_COUNT  (LINE_COUNT),
    .ROW_SPACING (ROW_SPACING),
    .COL_STEP    (COL_STEP)
  ) u_scan (
    .row           (s1_row_r),
    .col           (s1_col_r),
    .scan_row_base (scan_row_base_r),
    .col_start     (col_start_r),
    .col_end       (col_end_r),
    .hit           (scan_hit)
  );

  // ---------------- detector state ----------------
  logic          last_detect_r,      last_detect_nxt;
  logic          stopped_r,          stopped_nxt;
  logic [TW-1:0] stop_elapsed_r,     stop_elapsed_nxt;
  logic [TW-1:0] cooldown_elapsed_r, cooldown_elapsed_nxt;
  logic [NW-1:0] transition_total_r, transition_total_nxt;
  logic          level_white_r,      level_white_nxt;
  logic [CW-1:0] crossing_count_r,   crossing_count_nxt;

  // result fields computed in the pass
  logic          res_cross, res_started, res_released, res_cool;
  logic [NW-1:0] res_total;

  logic          white;
  logic          stopped_mid;
  logic [TW-1:0] elapsed_mid;
  logic [31:0]   detect_level;

  assign white        = s1_gray_r > gray_threshold_r;
  assign detect_level = 32'(min_transitions_r) * 32'(LINE_COUNT);

  always_comb begin
    last_detect_nxt      = last_detect_r;
    stopped_nxt          = stopped_r;
    stop_elapsed_nxt     = stop_elapsed_r;
    cooldown_elapsed_nxt = cooldown_elapsed_r;
    transition_total_nxt = transition_total_r;
    level_white_nxt      = level_white_r;
    crossing_count_nxt   = crossing_count_r;
    res_cross            = 1'b0;
    res_started          = 1'b0;
    res_released         = 1'b0;
    res_cool             = 1'b0;
    res_total            = '0;
    stopped_mid          = stopped_r;
    elapsed_mid          = stop_elapsed_r;

    if (s1_func_r == scd_pkg::FUNC_TICK) begin
      // advance elapsed-time counters, saturating
      if (stopped_r && (stop_elapsed_r != scd_pkg::TICK_MAX)) begin
        stop_elapsed_nxt = stop_elapsed_r + 1'b1;
      end
      if (cooldown_elapsed_r != scd_pkg::TICK_MAX) begin
        cooldown_elapsed_nxt = cooldown_elapsed_r + 1'b1;
      end
    end else begin
      // scan the pixel first
      if (scan_hit.hit) begin
        level_white_nxt = white;
        if (!scan_hit.first && (white != level_white_r) &&
            (transition_total_r != scd_pkg::TRANS_MAX)) begin
          transition_total_nxt = transition_total_r + 1'b1;
        end
      end

      // then evaluate the frame on its last pixel
      if (s1_last_r) begin
        res_total = transition_total_nxt;
        res_cool  = cooldown_elapsed_r < cooldown_ticks_r;
        if (!res_cool) begin
          res_cross = 32'(res_total) >= detect_level;
          if (res_cross && !last_detect_r && !stopped_r) begin
            res_started = 1'b1;
            stopped_mid = 1'b1;
            elapsed_mid = '0;
          end
          last_detect_nxt = res_cross;
        end
        stopped_nxt      = stopped_mid;
        stop_elapsed_nxt = elapsed_mid;
        if (stopped_mid && (elapsed_mid >= stop_ticks_r)) begin
          res_released         = 1'b1;
          stopped_nxt          = 1'b0;
          cooldown_elapsed_nxt = '0;
          if (crossing_count_r != scd_pkg::COUNT_MAX) begin
            crossing_count_nxt = crossing_count_r + 1'b1;
          end
        end
        transition_total_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_detect_r      <= 1'b0;
      stopped_r          <= 1'b0;
      stop_elapsed_r     <= '0;
      cooldown_elapsed_r <= scd_pkg::TICK_MAX;
      transition_total_r <= '0;
      level_white_r      <= 1'b0;
      crossing_count_r   <= '0;
    end else if (s1_adv) begin
      last_detect_r      <= last_detect_nxt;
      stopped_r          <= stopped_nxt;
      stop_elapsed_r     <= stop_elapsed_nxt;
      cooldown_elapsed_r <= cooldown_elapsed_nxt;
      transition_total_r <= transition_total_nxt;
      level_white_r      <= level_white_nxt;
      crossing_count_r   <= crossing_count_nxt;
    end
  end

  // ---------------- result register ----------------
  logic res_load;
  assign res_load = s1_adv && s1_result;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (out_xfer) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_vehicle_hold      <= stopped_nxt;
      out_crossing_now      <= res_cross;
      out_stop_started      <= res_started;
      out_stop_released     <= res_released;
      out_cool_active       <= res_cool;
      out_frame_transitions <= res_total;
      out_crossing_total    <= crossing_count_nxt;
    end
  end

endmodule

/* hw/rtl/scd_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scd_checker - port-level checks for the stop detector
// Watches the result channel for handshake and stop-state consistency.
// ----------------------------------------------------------------------------
module scd_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic                         out_vehicle_hold,
  input logic                         out_crossing_now,
  input logic                         out_stop_started,
  input logic                         out_stop_released,
  input logic                         out_cool_active,
  input logic [scd_pkg::TRANS_W-1:0]  out_frame_transitions,
  input logic [scd_pkg::COUNT_W-1:0]  out_crossing_total
);

  // A stalled result holds until it is taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_frame_transitions) &&
      $stable(out_crossing_total) && $stable(out_vehicle_hold))
    else $error("stalled result changed");

  // A stop only starts from a detected crossing
  a_start_needs_cross: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stop_started |-> out_crossing_now)
    else $error("stop started without a crossing");

  // No crossing is reported during cooldown
  a_no_cross_in_cool: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_crossing_now |-> !out_cool_active)
    else $error("crossing reported during cooldown");

  // A released stop leaves the vehicle free
  a_release_frees: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stop_released |-> !out_vehicle_hold)
    else $error("hold still set after release");

  // A new stop that is not released at once holds the vehicle
  a_start_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stop_started && !out_stop_released |-> out_vehicle_hold)
    else $error("stop started but no hold");

endmodule

bind scanline_crossing_stop_detector_unit scd_checker u_scd_checker (.*);

/* dv/scd_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scd_scoreboard - frame verdict predictor and scoreboard
// Follows register writes and input transfers on the detector ports, keeps
// its own copy of the scan, stop and cooldown state, predicts the verdict of
// every frame end and compares each result transfer field by field.
// ----------------------------------------------------------------------------
module scd_scoreboard
  import scd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [CFG_AW-1:0]  cfg_addr,
  input  logic [CFG_DW-1:0]  cfg_wdata,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               in_func,
  input  logic [GRAY_W-1:0]  in_gray,
  input  logic [POS_W-1:0]   in_row,
  input  logic [POS_W-1:0]   in_col,
  input  logic               in_frame_last,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               out_vehicle_hold,
  input  logic               out_crossing_now,
  input  logic               out_stop_started,
  input  logic               out_stop_released,
  input  logic               out_cool_active,
  input  logic [TRANS_W-1:0] out_frame_transitions,
  input  logic [COUNT_W-1:0] out_crossing_total,
  output int                 mismatches,
  output int                 verdicts_pending
);

  localparam int PRINT_CAP = 40;

  typedef struct packed {
    logic               hold;
    logic               crossing;
    logic               started;
    logic               released;
    logic               cooldown;
    logic [TRANS_W-1:0] transitions;
    logic [COUNT_W-1:0] total;
  } frame_verdict_t;

  frame_verdict_t frame_verdicts[$];

  // register copies
  logic [GRAY_W-1:0]  gray_thresh;
  logic [7:0]         min_trans;
  logic [TICK_W-1:0]  stop_len;
  logic [TICK_W-1:0]  cooldown_len;
  logic [POS_W-1:0]   row_base;
  logic [POS_W-1:0]   col_first;
  logic [POS_W-1:0]   col_stop;

  // detector state copies
  logic               last_detect;
  logic               stopped;
  logic               level_white;
  logic [TICK_W-1:0]  stop_elapsed;
  logic [TICK_W-1:0]  cooldown_elapsed;
  logic [TRANS_W-1:0] transition_total;
  logic [COUNT_W-1:0] crossing_count;

  int error_count = 0;

  task automatic report_mismatch(string what, int got, int want);
    error_count++;
    if (error_count <= PRINT_CAP)
      $display("[%0t] %s: got %0d, want %0d", $time, what, got, want);
  endtask

  // Scan one item into the state; queue the verdict of a frame end.
  task automatic advance_detector(logic func, logic [GRAY_W-1:0] gray,
                                  logic [POS_W-1:0] row, logic [POS_W-1:0] col,
                                  logic last);
    frame_verdict_t v;
    logic on_row, white, cool, crossed, started, released;
    int i;
    on_row   = 1'b0;
    crossed  = 1'b0;
    started  = 1'b0;
    released = 1'b0;
    if (func == FUNC_TICK) begin
      if (stopped && stop_elapsed != TICK_MAX) stop_elapsed++;
      if (cooldown_elapsed != TICK_MAX) cooldown_elapsed++;
    end else begin
      for (i = 0; i < LINE_COUNT_DEF; i++) begin
        if (i * ROW_SPACING_DEF <= int'(row_base) &&
            int'(row_base) - i * ROW_SPACING_DEF == int'(row))
          on_row = 1'b1;
      end
      if (on_row && col >= col_first && col < col_stop &&
          (int'(col - col_first) % COL_STEP_DEF) == 0) begin
        white = gray > gray_thresh;
        if (col == col_first) begin
          level_white = white;
        end else if (white != level_white) begin
          level_white = white;
          if (transition_total != TRANS_MAX) transition_total++;
        end
      end
      if (last) begin
        cool = cooldown_elapsed < cooldown_len;
        if (!cool) begin
          crossed = int'(transition_total) >= int'(min_trans) * LINE_COUNT_DEF;
          if (crossed && !last_detect && !stopped) begin
            stopped      = 1'b1;
            stop_elapsed = '0;
            started      = 1'b1;
          end
          last_detect = crossed;
        end
        if (stopped && stop_elapsed >= stop_len) begin
          stopped          = 1'b0;
          released         = 1'b1;
          cooldown_elapsed = '0;
          if (crossing_count != COUNT_MAX) crossing_count++;
        end
        v.hold        = stopped;
        v.crossing    = crossed;
        v.started     = started;
        v.released    = released;
        v.cooldown    = cool;
        v.transitions = transition_total;
        v.total       = crossing_count;
        frame_verdicts = {frame_verdicts, v};
        transition_total = '0;
      end
    end
  endtask

  always @(posedge clk) begin
    frame_verdict_t want;
    if (!rst_n) begin
      gray_thresh      = GRAY_THRESHOLD_RST;
      min_trans        = MIN_TRANSITIONS_RST;
      stop_len         = STOP_TICKS_RST;
      cooldown_len     = COOLDOWN_TICKS_RST;
      row_base         = SCAN_ROW_BASE_RST;
      col_first        = COL_START_RST;
      col_stop         = COL_END_RST;
      last_detect      = 1'b0;
      stopped          = 1'b0;
      level_white      = 1'b0;
      stop_elapsed     = '0;
      cooldown_elapsed = TICK_MAX;
      transition_total = '0;
      crossing_count   = '0;
      frame_verdicts.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_GRAY_THRESHOLD:  gray_thresh  = cfg_wdata[GRAY_W-1:0];
          REG_MIN_TRANSITIONS: min_trans    = cfg_wdata[7:0];
          REG_STOP_TICKS:      stop_len     = cfg_wdata[TICK_W-1:0];
          REG_COOLDOWN_TICKS:  cooldown_len = cfg_wdata[TICK_W-1:0];
          REG_SCAN_ROW_BASE:   row_base     = cfg_wdata[POS_W-1:0];
          REG_COL_START:       col_first    = cfg_wdata[POS_W-1:0];
          REG_COL_END:         col_stop     = cfg_wdata[POS_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (frame_verdicts.size() == 0) begin
          report_mismatch("result with no frame end pending",
                          int'(out_frame_transitions), 0);
        end else begin
          want = frame_verdicts.pop_front();
          if (out_vehicle_hold !== want.hold)
            report_mismatch("vehicle_hold", int'(out_vehicle_hold), int'(want.hold));
          if (out_crossing_now !== want.crossing)
            report_mismatch("crossing_now", int'(out_crossing_now), int'(want.crossing));
          if (out_stop_started !== want.started)
            report_mismatch("stop_started", int'(out_stop_started), int'(want.started));
          if (out_stop_released !== want.released)
            report_mismatch("stop_released", int'(out_stop_released),
                            int'(want.released));
          if (out_cool_active !== want.cooldown)
            report_mismatch("cool_active", int'(out_cool_active), int'(want.cooldown));
          if (out_frame_transitions !== want.transitions)
            report_mismatch("frame_transitions", int'(out_frame_transitions),
                            int'(want.transitions));
          if (out_crossing_total !== want.total)
            report_mismatch("crossing_total", int'(out_crossing_total),
                            int'(want.total));
        end
      end
      if (in_valid && !in_stall)
        advance_detector(in_func, in_gray, in_row, in_col, in_frame_last);
    end
    mismatches       <= error_count;
    verdicts_pending <= frame_verdicts.size();
  end

endmodule

/* dv/scanline_crossing_stop_detector_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scanline_crossing_stop_detector_unit_tb - detector stimulus and verdict
// Drives pixel and tick transfers shaped as scan-row frames under a series
// of register settings, stalls the result channel on its own pattern and
// leaves prediction and comparison to the checker beside the block.
// ----------------------------------------------------------------------------
module scanline_crossing_stop_detector_unit_tb;
  import scd_pkg::*;

  // Two register stages between a frame end transfer and its result
  localparam int LATENCY        = 2;
  // Watchdog limit, above the longest quiet stretch of a blocked receiver or a sender gap
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int ITEM_GOAL      = 1500;
  localparam int FRAME_GOAL     = 60;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_RANDOM,
    RX_PERIODIC,
    RX_BLOCKED
  } rx_mode_t;

  logic               clk           = 1'b0;
  logic               rst_n         = 1'b0;
  logic               cfg_we        = 1'b0;
  logic [CFG_AW-1:0]  cfg_addr      = '0;
  logic [CFG_DW-1:0]  cfg_wdata     = '0;
  logic               in_valid      = 1'b0;
  logic               in_stall;
  logic               in_func       = FUNC_PIXEL;
  logic [GRAY_W-1:0]  in_gray       = '0;
  logic [POS_W-1:0]   in_row        = '0;
  logic [POS_W-1:0]   in_col        = '0;
  logic               in_frame_last = 1'b0;
  logic               out_valid;
  logic               out_stall     = 1'b0;
  logic               out_vehicle_hold;
  logic               out_crossing_now;
  logic               out_stop_started;
  logic               out_stop_released;
  logic               out_cool_active;
  logic [TRANS_W-1:0] out_frame_transitions;
  logic [COUNT_W-1:0] out_crossing_total;

  int mismatches;
  int verdicts_pending;

  // Register values as last written, used to aim pixels at the scan window
  logic [GRAY_W-1:0]  thresh_now    = GRAY_THRESHOLD_RST;
  logic [POS_W-1:0]   base_now      = SCAN_ROW_BASE_RST;
  logic [POS_W-1:0]   col_first_now = COL_START_RST;

  int       burst_left    = 0;
  int       items_sent    = 0;
  int       frames_closed = 0;
  int       quiet_cycles  = 0;
  int       stall_left    = 0;
  rx_mode_t rx_mode       = RX_OPEN;

  scanline_crossing_stop_detector_unit dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_addr             (cfg_addr),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_func              (in_func),
    .in_gray              (in_gray),
    .in_row               (in_row),
    .in_col               (in_col),
    .in_frame_last        (in_frame_last),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_vehicle_hold     (out_vehicle_hold),
    .out_crossing_now     (out_crossing_now),
    .out_stop_started     (out_stop_started),
    .out_stop_released    (out_stop_released),
    .out_cool_active      (out_cool_active),
    .out_frame_transitions(out_frame_transitions),
    .out_crossing_total   (out_crossing_total)
  );

  scd_scoreboard verdict_check (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_addr             (cfg_addr),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_func              (in_func),
    .in_gray              (in_gray),
    .in_row               (in_row),
    .in_col               (in_col),
    .in_frame_last        (in_frame_last),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_vehicle_hold     (out_vehicle_hold),
    .out_crossing_now     (out_crossing_now),
    .out_stop_started     (out_stop_started),
    .out_stop_released    (out_stop_released),
    .out_cool_active      (out_cool_active),
    .out_frame_transitions(out_frame_transitions),
    .out_crossing_total   (out_crossing_total),
    .mismatches           (mismatches),
    .verdicts_pending     (verdicts_pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Receiver: switch between open, random, periodic and fully blocked
  // segments so stalls land on every phase of the block's work.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      rx_mode    <= rx_mode_t'($urandom_range(0, 3));
      stall_left <= $urandom_range(20, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (rx_mode)
      RX_OPEN:     out_stall <= 1'b0;
      RX_RANDOM:   out_stall <= ($urandom_range(0, 99) < 30);
      RX_PERIODIC: out_stall <= ((stall_left % 16) < 10);
      default:     out_stall <= 1'b1;
    endcase
  end

  // Watchdog: end the run when no transfer happens for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Present one item and hold it until the transfer; whenever the current
  // burst has run out, first open a random gap, which may be empty.
  task automatic send_item(logic func, logic [GRAY_W-1:0] gray,
                           logic [POS_W-1:0] row, logic [POS_W-1:0] col,
                           logic last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 3);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 300)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid      <= 1'b1;
    in_func       <= func;
    in_gray       <= gray;
    in_row        <= row;
    in_col        <= col;
    in_frame_last <= last;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (func == FUNC_PIXEL && last) frames_closed++;
  endtask

  // A tick carries random pixel fields; the block must ignore them.
  task automatic send_tick();
    send_item(FUNC_TICK, GRAY_W'($urandom_range(0, 255)), POS_W'($urandom_range(0, 2047)),
              POS_W'($urandom_range(0, 2047)), 1'($urandom_range(0, 1)));
  endtask

  task automatic send_noise(logic last);
    send_item(FUNC_PIXEL, GRAY_W'($urandom_range(0, 255)), POS_W'($urandom_range(0, 2047)),
              POS_W'($urandom_range(0, 2047)), last);
  endtask

  // Pick a gray value on the requested side of the current threshold
  function automatic logic [GRAY_W-1:0] gray_for(bit white);
    if (white && thresh_now != 8'hFF)
      gray_for = GRAY_W'($urandom_range(255, int'(thresh_now) + 1));
    else if (white)
      gray_for = 8'hFF;
    else
      gray_for = GRAY_W'($urandom_range(int'(thresh_now), 0));
  endfunction

  // Stop sending, let every pending result arrive, then let the pipe settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (verdicts_pending != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  // Write all seven registers back to back; call only with the block idle
  task automatic program_regs(int thresh, int min_tr, int stop_t, int cool_t,
                              int base, int c_first, int c_stop);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_GRAY_THRESHOLD;
    cfg_wdata <= CFG_DW'(thresh);
    @(posedge clk);
    cfg_addr  <= REG_MIN_TRANSITIONS;
    cfg_wdata <= CFG_DW'(min_tr);
    @(posedge clk);
    cfg_addr  <= REG_STOP_TICKS;
    cfg_wdata <= CFG_DW'(stop_t);
    @(posedge clk);
    cfg_addr  <= REG_COOLDOWN_TICKS;
    cfg_wdata <= CFG_DW'(cool_t);
    @(posedge clk);
    cfg_addr  <= REG_SCAN_ROW_BASE;
    cfg_wdata <= CFG_DW'(base);
    @(posedge clk);
    cfg_addr  <= REG_COL_START;
    cfg_wdata <= CFG_DW'(c_first);
    @(posedge clk);
    cfg_addr  <= REG_COL_END;
    cfg_wdata <= CFG_DW'(c_stop);
    @(posedge clk);
    cfg_we    <= 1'b0;
    thresh_now    = GRAY_W'(thresh);
    base_now      = POS_W'(base);
    col_first_now = POS_W'(c_first);
  endtask

  // One frame: most scan rows get a reference sample and a run of samples
  // that mostly flip level, with ticks, noise and stray frame ends mixed in.
  task automatic send_frame();
    int ln, j, k;
    bit level;
    logic [POS_W-1:0] row, col;
    for (ln = 0; ln < LINE_COUNT_DEF; ln++) begin
      if ($urandom_range(0, 9) < 8) begin
        row   = POS_W'(int'(base_now) - ln * ROW_SPACING_DEF);
        level = 1'($urandom_range(0, 1));
        send_item(FUNC_PIXEL, gray_for(level), row, col_first_now, 1'b0);
        k = $urandom_range(0, 8);
        for (j = 1; j <= k; j++) begin
          if ($urandom_range(0, 4) != 0) level = !level;
          col = POS_W'(int'(col_first_now) + j * COL_STEP_DEF);
          // now and then land between sample columns
          if ($urandom_range(0, 9) == 0)
            col = col + POS_W'($urandom_range(1, COL_STEP_DEF - 1));
          send_item(FUNC_PIXEL, gray_for(level), row, col, 1'b0);
          case ($urandom_range(0, 29))
            0, 1, 2, 3: send_tick();
            4, 5:       send_noise(1'b0);
            6:          send_noise(1'b1);
            default: ;
          endcase
        end
      end
    end
    // Close the frame: sometimes on a sample point so it is scanned too
    if ($urandom_range(0, 2) == 0)
      send_item(FUNC_PIXEL, gray_for(1'($urandom_range(0, 1))), base_now,
                POS_W'(int'(col_first_now) + COL_STEP_DEF * int'($urandom_range(0, 8))),
                1'b1);
    else
      send_noise(1'b1);
  endtask

  initial begin
    int phase;
    int c_first, c_stop;
    phase = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Defaults: tick with cooldown already saturated, then a short frame
    // through the scan window; the frame end lands on the last sample.
    send_tick();
    send_item(FUNC_PIXEL, 8'd161, 11'd120, 11'd32, 1'b0);    // reference white
    send_item(FUNC_PIXEL, 8'd0, 11'd120, 11'd33, 1'b0);      // between samples
    send_item(FUNC_PIXEL, 8'd160, 11'd120, 11'd35, 1'b0);    // at threshold: black
    send_item(FUNC_PIXEL, 8'd255, 11'd115, 11'd38, 1'b0);
    send_item(FUNC_PIXEL, 8'd0, 11'd119, 11'd41, 1'b0);      // not a scan row
    send_item(FUNC_PIXEL, 8'd255, 11'd95, 11'd44, 1'b0);     // above the top scan row
    send_item(FUNC_PIXEL, 8'd0, 11'd120, 11'd288, 1'b0);     // window end, excluded
    send_item(FUNC_PIXEL, 8'd255, 11'd2047, 11'd2047, 1'b0);
    send_item(FUNC_PIXEL, 8'd0, 11'd100, 11'd287, 1'b1);

    // Empty window, zero minimum and zero stop time: the first frame end
    // starts and releases a stop at once, the next sits in cooldown, and
    // after two ticks the held detection must not start another stop.
    drain();
    program_regs(0, 0, 0, 2, 20, 0, 0);
    send_item(FUNC_PIXEL, 8'd255, 11'd20, 11'd0, 1'b1);
    send_item(FUNC_PIXEL, 8'd255, 11'd0, 11'd0, 1'b1);
    send_tick();
    send_tick();
    send_item(FUNC_PIXEL, 8'd0, 11'd5, 11'd0, 1'b1);

    // Random phases: all-high settings, then low settings with a wide window, then mixed
    while (items_sent < ITEM_GOAL || frames_closed < FRAME_GOAL) begin
      drain();
      case (phase)
        0: program_regs(255, 255, 16'hFFFF, 16'hFFFF, 2047, 2047, 2047);
        1: program_regs(0, 0, 0, 0, 20, 0, 2047);
        default: begin
          c_first = $urandom_range(0, 2000);
          c_stop  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, c_first)
                                                : c_first + $urandom_range(1, 40);
          program_regs(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                   : $urandom_range(60, 200),
                       ($urandom_range(0, 5) == 0) ? $urandom_range(0, 255)
                                                   : $urandom_range(0, 3),
                       $urandom_range(0, 12), $urandom_range(0, 25),
                       $urandom_range(20, 2047), c_first, c_stop);
        end
      endcase
      repeat ($urandom_range(3, 10)) begin
        send_frame();
        // advance time between frames so stops expire and cooldowns end
        if ($urandom_range(0, 2) == 0)
          repeat ($urandom_range(1, 15)) send_tick();
      end
      phase++;
    end

    drain();
    if (mismatches == 0 && verdicts_pending == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
